/* rtl/mrt_pkg.sv */
// Shared types and constants of the message rate throttle.
// Depends on nothing; every other file of the block uses it.
package mrt_pkg;

  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BYTES_WIDTH = 16;
  localparam int unsigned REG_WIDTH = 32;
  localparam int unsigned USED_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  localparam int unsigned BUDGET_WIDTH = REG_WIDTH + TIME_WIDTH;
  localparam int unsigned LHS_WIDTH = USED_WIDTH + FRAC_BITS;
  localparam int unsigned CMP_WIDTH = (BUDGET_WIDTH > LHS_WIDTH) ? BUDGET_WIDTH : LHS_WIDTH;
  localparam int unsigned GAP_WIDTH = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MSG  = 1'b1
  } mrt_op_e;

  typedef enum logic {
    MODE_FREQ = 1'b0,
    MODE_BW   = 1'b1
  } mrt_mode_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_MODE    = 2'd0,
    CFG_MIN_GAP = 2'd1,
    CFG_BPT     = 2'd2
  } mrt_cfg_idx_e;

  typedef struct packed {
    mrt_mode_e             mode;
    logic [REG_WIDTH-1:0]  min_gap_ticks;
    logic [REG_WIDTH-1:0]  bytes_per_tick_q;
  } mrt_cfg_t;

  typedef struct packed {
    logic grant;
    logic over_budget;
  } mrt_res_t;

endpackage

/* rtl/mrt_if.sv */
// Valid/ready channel interfaces for requests and decisions.
// Depends on mrt_pkg for the field widths.
interface mrt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [mrt_pkg::BYTES_WIDTH-1:0]  byte_count;

  modport source (output valid, output op, output byte_count, input ready);
  modport sink (input valid, input op, input byte_count, output ready);
endinterface

interface mrt_out_if;
  logic valid;
  logic ready;
  logic grant;
  logic over_budget;

  modport source (output valid, output grant, output over_budget, input ready);
  modport sink (input valid, input grant, input over_budget, output ready);
endinterface

/* rtl/message_rate_throttle.sv */
// Message rate throttle top level: configuration registers, input register,
// result register. Depends on mrt_pkg, mrt_if and mrt_core.
//
// The block takes one transaction per cycle on its input channel, tick or
// message request alike, and a message request's decision is registered
// in the result register until the output channel takes it. The rate is
// set by the update of the throttle state: the budget is kept as a running
// sum of bytes per tick, so each item needs only one wide compare and one
// add. The input stalls only while a decision waits in the result register
// and the next item is a message request. Configuration writes clear the
// throttle state and are meant to be made while the block is idle.
module message_rate_throttle (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mrt_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [mrt_pkg::REG_WIDTH-1:0]     cfg_wdata_i,
  mrt_in_if.sink                            in_i,
  mrt_out_if.source                         out_o
);

  mrt_pkg::mrt_cfg_t cfg_q, cfg_d;
  logic              cfg_clear;

  logic                            s1_valid_q, s1_valid_d;
  logic                            s1_op_q;
  logic [mrt_pkg::BYTES_WIDTH-1:0] s1_bytes_q;
  logic                            s1_adv;
  logic                            s1_is_msg;

  logic              out_valid_q, out_valid_d;
  mrt_pkg::mrt_res_t out_res_q;
  mrt_pkg::mrt_res_t core_res;

  always_comb begin
    cfg_d = cfg_q;
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (mrt_pkg::mrt_cfg_idx_e'(cfg_idx_i))
        mrt_pkg::CFG_MODE: begin
          cfg_d.mode = mrt_pkg::mrt_mode_e'(cfg_wdata_i[0]);
          cfg_clear = 1'b1;
        end
        mrt_pkg::CFG_MIN_GAP: begin
          cfg_d.min_gap_ticks = cfg_wdata_i;
          cfg_clear = 1'b1;
        end
        mrt_pkg::CFG_BPT: begin
          cfg_d.bytes_per_tick_q = cfg_wdata_i;
          cfg_clear = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  assign s1_is_msg = mrt_pkg::mrt_op_e'(s1_op_q) == mrt_pkg::OP_MSG;
  assign s1_adv = s1_valid_q && (!s1_is_msg || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_is_msg) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  mrt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_clear),
    .cfg_i   (cfg_q),
    .step_i  (s1_adv),
    .op_i    (s1_op_q),
    .bytes_i (s1_bytes_q),
    .res_o   (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q <= in_i.op;
      s1_bytes_q <= in_i.byte_count;
    end
    if (s1_adv && s1_is_msg) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.grant = out_res_q.grant;
  assign out_o.over_budget = out_res_q.over_budget;

endmodule

/* rtl/mrt_core.sv */
// Throttle state and the per-item grant decision.
// Depends on mrt_pkg; instantiated by message_rate_throttle.
module mrt_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  mrt_pkg::mrt_cfg_t               cfg_i,
  input  logic                            step_i,
  input  logic                            op_i,
  input  logic [mrt_pkg::BYTES_WIDTH-1:0] bytes_i,
  output mrt_pkg::mrt_res_t               res_o
);

  localparam logic [mrt_pkg::TIME_WIDTH-1:0] TimeMax = '1;
  localparam logic [mrt_pkg::USED_WIDTH-1:0] UsedMax = '1;

  // The budget register always equals bytes_per_tick_q times elapsed_q.
  logic [mrt_pkg::TIME_WIDTH-1:0]   elapsed_q, elapsed_d;
  logic [mrt_pkg::USED_WIDTH-1:0]   used_q, used_d;
  logic [mrt_pkg::BUDGET_WIDTH-1:0] budget_q, budget_d;
  logic                             exceeded_q, exceeded_d;

  logic [mrt_pkg::LHS_WIDTH-1:0]    lhs;
  logic                             under;
  logic                             gap_ok;
  logic [mrt_pkg::USED_WIDTH:0]     used_sum;

  assign lhs = mrt_pkg::LHS_WIDTH'(used_q) << mrt_pkg::FRAC_BITS;
  assign under = mrt_pkg::CMP_WIDTH'(lhs) < mrt_pkg::CMP_WIDTH'(budget_q);
  assign gap_ok = (cfg_i.min_gap_ticks != '0) &&
                  (mrt_pkg::GAP_WIDTH'(elapsed_q) > mrt_pkg::GAP_WIDTH'(cfg_i.min_gap_ticks));
  assign used_sum = (mrt_pkg::USED_WIDTH + 1)'(used_q) + (mrt_pkg::USED_WIDTH + 1)'(bytes_i);

  always_comb begin
    elapsed_d = elapsed_q;
    used_d = used_q;
    budget_d = budget_q;
    exceeded_d = exceeded_q;
    res_o.grant = 1'b0;
    if (step_i) begin
      if (mrt_pkg::mrt_op_e'(op_i) == mrt_pkg::OP_TICK) begin
        if (elapsed_q != TimeMax) begin
          elapsed_d = elapsed_q + 1'b1;
          budget_d = budget_q + mrt_pkg::BUDGET_WIDTH'(cfg_i.bytes_per_tick_q);
        end
      end else if (cfg_i.mode == mrt_pkg::MODE_FREQ) begin
        if (gap_ok) begin
          res_o.grant = 1'b1;
          elapsed_d = '0;
          budget_d = '0;
        end
      end else if (cfg_i.bytes_per_tick_q != '0) begin
        if (exceeded_q) begin
          if (under) begin
            elapsed_d = '0;
            budget_d = '0;
            used_d = '0;
            exceeded_d = 1'b0;
          end
        end else if (under) begin
          res_o.grant = 1'b1;
          used_d = used_sum[mrt_pkg::USED_WIDTH] ? UsedMax
                                                 : used_sum[mrt_pkg::USED_WIDTH-1:0];
        end else begin
          exceeded_d = 1'b1;
        end
      end
    end
    res_o.over_budget = exceeded_d;
    if (clear_i) begin
      elapsed_d = '0;
      used_d = '0;
      budget_d = '0;
      exceeded_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      used_q <= '0;
      budget_q <= '0;
      exceeded_q <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      used_q <= used_d;
      budget_q <= budget_d;
      exceeded_q <= exceeded_d;
    end
  end

endmodule
